// ===== src/hbpc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hbpc_pkg
// Shared types, widths and the CRC step for the Huffman bit packer with CRC.
// ----------------------------------------------------------------------------
package hbpc_pkg;

   localparam int SYM_W      = 8;   // symbol width
   localparam int LEN_W      = 6;   // code length width, lengths 0 to 32
   localparam int CODE_W     = 32;  // code bit width
   localparam int BUF_W      = 40;  // bit buffer: up to 7 residual bits plus a 32-bit code
   localparam int CNT_W      = 6;   // bit count, 0 to 39
   localparam int CRC_W      = 32;
   localparam int COUNT_W    = 32;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 104;
   localparam int RSP_USER_W = 3;

   localparam int MAX_CODE_LEN_DEF = 32;
   localparam int SYMBOL_COUNT_DEF = 256;

   localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;
   localparam logic [CRC_W-1:0] CRC_TOP  = 32'h8000_0000;

   typedef enum logic [1:0] {
      KIND_LOAD   = 2'd0,
      KIND_ENCODE = 2'd1,
      KIND_CLEAR  = 2'd2
   } kind_type;

   // One byte of CRC, data bits taken least significant first.
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [SYM_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = crc;
      for (int b = 0; b < SYM_W; b++) begin
         if (((c & CRC_TOP) != '0) != data[b]) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== src/huffman_bit_packer_with_crc.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// huffman_bit_packer_with_crc
// Path: an accepted request is registered into the second stage; its results leave through the rsp port registers.
// Throughput: one request per cycle while each encode completes at most one output byte and
// the output is not stalled; an encode completing more holds the next until all but its
// last byte have left; a final encode holds it until any partial byte and the summary leave.
// Reset: synchronous; valid bits, stream state and the halt flag clear at once, no sweep.
// ----------------------------------------------------------------------------
// The code table lives in a single synchronous memory of SYMBOL_COUNT entries,
// each holding the saturated length and the pre-masked code. Table loads write
// the memory as they are accepted; every request reads its entry in the same
// cycle, so the data is registered and ready when the request reaches the
// second stage. Because only one request is in the second stage and a new one
// is accepted only as it leaves, a read can never overtake an earlier write.
//
// The second stage holds the packing engine: a 40-bit bit buffer, a bit count,
// the CRC and the two stream counters. Each cycle the engine may hand one byte
// to the output register; in that same cycle the next encode may merge its code
// into what is left, provided fewer than eight bits will remain and no flush or
// summary is still pending. Error results, flush bytes and summaries also leave
// through the engine, which keeps all results in request order.
// ----------------------------------------------------------------------------
module huffman_bit_packer_with_crc #(
   parameter int MAX_CODE_LEN = hbpc_pkg::MAX_CODE_LEN_DEF,
   parameter int SYMBOL_COUNT = hbpc_pkg::SYMBOL_COUNT_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // Request channel
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // tdata, lowest bit up: symbol [7:0], code_length [13:8], code_bits [45:14], zero [47:46]
   input  wire  [hbpc_pkg::REQ_DATA_W-1:0]      req_tdata,
   // tuser: kind [1:0]
   input  wire  [1:0]                           req_tuser,
   // tlast: final_byte
   input  wire                                  req_tlast,
   // Result channel
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // tdata, lowest bit up: out_byte [7:0], crc_value [39:8], original_count [71:40],
   // compressed_count [103:72]
   output logic [hbpc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // tuser, lowest bit up: byte_valid [0], status [1], stream_done [2]
   output logic [hbpc_pkg::RSP_USER_W-1:0]      rsp_tuser,
   // tlast: last_of_run
   output logic                                 rsp_tlast
);

   localparam int SYM_W   = hbpc_pkg::SYM_W;
   localparam int LEN_W   = hbpc_pkg::LEN_W;
   localparam int CODE_W  = hbpc_pkg::CODE_W;
   localparam int BUF_W   = hbpc_pkg::BUF_W;
   localparam int CNT_W   = hbpc_pkg::CNT_W;
   localparam int CRC_W   = hbpc_pkg::CRC_W;
   localparam int COUNT_W = hbpc_pkg::COUNT_W;
   localparam int ADDR_W  = $clog2(SYMBOL_COUNT);
   localparam int ENTRY_W = LEN_W + CODE_W;

   localparam logic [SYM_W:0]   SYM_LIMIT = (SYM_W + 1)'(SYMBOL_COUNT);
   localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_CODE_LEN);
   localparam logic [CNT_W-1:0] BYTE_BITS = CNT_W'(8);

   // ------------------------------------------------------------------------
   // Request decode
   // ------------------------------------------------------------------------
   hbpc_pkg::kind_type       req_kind;
   logic [SYM_W-1:0]         req_symbol;
   logic [LEN_W-1:0]         req_length;
   logic [CODE_W-1:0]        req_code;
   logic                     req_accept;
   logic                     req_in_range;
   logic [LEN_W-1:0]         len_sat;
   logic [CODE_W:0]          len_mask;
   logic [CODE_W-1:0]        code_masked;
   logic                     load_wr;

   assign req_kind     = hbpc_pkg::kind_type'(req_tuser);
   assign req_symbol   = req_tdata[7:0];
   assign req_length   = req_tdata[13:8];
   assign req_code     = req_tdata[45:14];
   assign req_accept   = req_tvalid && req_tready;
   assign req_in_range = {1'b0, req_symbol} < SYM_LIMIT;
   assign len_sat      = (req_length > LEN_MAX) ? LEN_MAX : req_length;
   assign len_mask     = ((CODE_W + 1)'(1) << len_sat) - (CODE_W + 1)'(1);
   assign code_masked  = req_code & len_mask[CODE_W-1:0];
   assign load_wr      = req_accept && (req_kind == hbpc_pkg::KIND_LOAD) && req_in_range;

   // ------------------------------------------------------------------------
   // Code table memory: one write port, one registered read port.
   // ------------------------------------------------------------------------
   logic [ENTRY_W-1:0] entry_mem [SYMBOL_COUNT];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (load_wr) begin
         entry_mem[req_symbol[ADDR_W-1:0]] <= {len_sat, code_masked};
      end
      if (req_accept) begin
         rd_data_ff <= entry_mem[req_symbol[ADDR_W-1:0]];
      end
   end

   // ------------------------------------------------------------------------
   // Second stage and packing engine state
   // ------------------------------------------------------------------------
   logic                     s1_valid_ff, s1_valid_in;
   hbpc_pkg::kind_type       s1_kind_ff;
   logic [SYM_W-1:0]         s1_symbol_ff;
   logic                     s1_in_range_ff;
   logic                     s1_final_ff;

   logic [SYMBOL_COUNT-1:0]  valid_ff, valid_in;
   logic [BUF_W-1:0]         buf_ff, buf_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [CRC_W-1:0]         crc_ff, crc_in;
   logic [COUNT_W-1:0]       in_count_ff, in_count_in;
   logic [COUNT_W-1:0]       out_count_ff, out_count_in;
   logic                     fin_pend_ff, fin_pend_in;
   logic                     halt_ff, halt_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               rsp_byte_ff, rsp_byte_in;
   logic                     rsp_bvalid_ff, rsp_bvalid_in;
   logic                     rsp_status_ff, rsp_status_in;
   logic [CRC_W-1:0]         rsp_crc_ff, rsp_crc_in;
   logic [COUNT_W-1:0]       rsp_orig_ff, rsp_orig_in;
   logic [COUNT_W-1:0]       rsp_comp_ff, rsp_comp_in;
   logic                     rsp_done_ff, rsp_done_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic [LEN_W-1:0]         entry_len;
   logic [CODE_W-1:0]        entry_code;
   logic                     out_free;
   logic                     emit_byte;
   logic [CNT_W-1:0]         cnt_after;
   logic [BUF_W-1:0]         buf_after;
   logic                     settled;
   logic                     is_encode;
   logic                     is_clear;
   logic                     entry_ok;
   logic                     enc_live;
   logic                     pack_go;
   logic                     err_go;
   logic                     clr_go;
   logic                     flush_go;
   logic                     sum_go;
   logic                     s1_adv;
   logic [7:0]               data_byte;
   logic [7:0]               flush_byte;

   assign entry_len  = rd_data_ff[CODE_W +: LEN_W];
   assign entry_code = rd_data_ff[CODE_W-1:0];

   always_comb begin
      is_encode = 1'b0;
      is_clear  = 1'b0;
      case (s1_kind_ff)
         hbpc_pkg::KIND_ENCODE: is_encode = 1'b1;
         hbpc_pkg::KIND_CLEAR:  is_clear  = 1'b1;
         default: begin
            is_encode = 1'b0;
            is_clear  = 1'b0;
         end
      endcase
   end

   always_comb begin
      // The output register can take a result when empty or being drained.
      out_free  = !rsp_valid_ff || rsp_tready;
      emit_byte = out_free && (cnt_ff >= BYTE_BITS);
      cnt_after = emit_byte ? (cnt_ff - BYTE_BITS) : cnt_ff;
      // Only the bits still owed stay in the buffer.
      buf_after = buf_ff & ~({BUF_W{1'b1}} << cnt_after);
      settled   = !fin_pend_ff && (cnt_after < BYTE_BITS);

      entry_ok  = s1_in_range_ff && valid_ff[s1_symbol_ff[ADDR_W-1:0]];
      enc_live  = s1_valid_ff && is_encode && !halt_ff;
      pack_go   = enc_live && entry_ok && settled;
      // An error result must follow every byte of earlier encodes.
      err_go    = enc_live && !entry_ok && out_free && !fin_pend_ff && (cnt_ff < BYTE_BITS);
      clr_go    = s1_valid_ff && is_clear && settled;
      flush_go  = out_free && fin_pend_ff && (cnt_ff != '0) && (cnt_ff < BYTE_BITS);
      sum_go    = out_free && fin_pend_ff && (cnt_ff == '0);
      // Loads, unknown kinds and encodes of a halted stream pass straight through.
      s1_adv    = s1_valid_ff && (pack_go || err_go || clr_go || !(is_clear || enc_live));

      data_byte  = 8'(buf_ff >> (cnt_ff - BYTE_BITS));
      flush_byte = buf_ff[7:0] << (4'd8 - {1'b0, cnt_ff[2:0]});
   end

   assign req_tready  = !s1_valid_ff || s1_adv;
   assign s1_valid_in = req_accept ? 1'b1 : (s1_valid_ff && !s1_adv);

   // Engine next state.
   always_comb begin
      buf_in       = buf_ff;
      cnt_in       = cnt_ff;
      crc_in       = crc_ff;
      in_count_in  = in_count_ff;
      out_count_in = out_count_ff;
      fin_pend_in  = fin_pend_ff;
      halt_in      = halt_ff;
      valid_in     = valid_ff;

      if (emit_byte) begin
         buf_in       = buf_after;
         cnt_in       = cnt_after;
         out_count_in = out_count_ff + COUNT_W'(1);
      end
      if (flush_go) begin
         buf_in       = '0;
         cnt_in       = '0;
         out_count_in = out_count_ff + COUNT_W'(1);
      end
      if (pack_go) begin
         buf_in      = (buf_after << entry_len) | BUF_W'(entry_code);
         cnt_in      = cnt_after + CNT_W'(entry_len);
         crc_in      = hbpc_pkg::crc_byte(crc_ff, s1_symbol_ff);
         in_count_in = in_count_ff + COUNT_W'(1);
         fin_pend_in = s1_final_ff;
      end
      if (sum_go || clr_go) begin
         buf_in       = '0;
         cnt_in       = '0;
         crc_in       = '0;
         in_count_in  = '0;
         out_count_in = '0;
         fin_pend_in  = 1'b0;
      end
      if (clr_go) begin
         halt_in  = 1'b0;
         valid_in = '0;
      end
      if (err_go) begin
         halt_in = 1'b1;
      end
      // A load accepted as the clear leaves is later in order, so it wins.
      if (load_wr) begin
         valid_in[req_symbol[ADDR_W-1:0]] = 1'b1;
      end
   end

   // Result selection into the output register.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_bvalid_in = rsp_bvalid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_crc_in    = rsp_crc_ff;
      rsp_orig_in   = rsp_orig_ff;
      rsp_comp_in   = rsp_comp_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_last_in   = rsp_last_ff;

      if (emit_byte || flush_go || sum_go || err_go) begin
         rsp_valid_in  = 1'b1;
         rsp_crc_in    = crc_ff;
         rsp_orig_in   = in_count_ff;
         rsp_comp_in   = out_count_ff;
         rsp_byte_in   = '0;
         rsp_bvalid_in = 1'b0;
         rsp_status_in = 1'b0;
         rsp_done_in   = 1'b0;
         rsp_last_in   = 1'b1;
         if (emit_byte) begin
            rsp_byte_in   = data_byte;
            rsp_bvalid_in = 1'b1;
            rsp_comp_in   = out_count_ff + COUNT_W'(1);
            rsp_last_in   = !fin_pend_ff && (cnt_after < BYTE_BITS);
         end else if (flush_go) begin
            rsp_byte_in   = flush_byte;
            rsp_bvalid_in = 1'b1;
            rsp_comp_in   = out_count_ff + COUNT_W'(1);
            rsp_last_in   = 1'b0;
         end else if (sum_go) begin
            rsp_done_in   = 1'b1;
         end else begin
            rsp_status_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         valid_ff     <= '0;
         buf_ff       <= '0;
         cnt_ff       <= '0;
         crc_ff       <= '0;
         in_count_ff  <= '0;
         out_count_ff <= '0;
         fin_pend_ff  <= 1'b0;
         halt_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         valid_ff     <= valid_in;
         buf_ff       <= buf_in;
         cnt_ff       <= cnt_in;
         crc_ff       <= crc_in;
         in_count_ff  <= in_count_in;
         out_count_ff <= out_count_in;
         fin_pend_ff  <= fin_pend_in;
         halt_ff      <= halt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_kind_ff     <= req_kind;
         s1_symbol_ff   <= req_symbol;
         s1_in_range_ff <= req_in_range;
         s1_final_ff    <= req_tlast;
      end
      rsp_byte_ff   <= rsp_byte_in;
      rsp_bvalid_ff <= rsp_bvalid_in;
      rsp_status_ff <= rsp_status_in;
      rsp_crc_ff    <= rsp_crc_in;
      rsp_orig_ff   <= rsp_orig_in;
      rsp_comp_ff   <= rsp_comp_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_comp_ff, rsp_orig_ff, rsp_crc_ff, rsp_byte_ff};
   assign rsp_tuser  = {rsp_done_ff, rsp_status_ff, rsp_bvalid_ff};
   assign rsp_tlast  = rsp_last_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   // The buffer never holds more than seven residual bits plus one code.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(BUF_W - 1))
      else $error("bit count beyond buffer");

   // No new code may merge while a flush or summary is still owed.
   a_no_pack_pending: assert property (@(posedge clock) disable iff (reset)
      fin_pend_ff |-> !pack_go)
      else $error("pack while stream end pending");

   // An error result halts the stream.
   a_err_halts: assert property (@(posedge clock) disable iff (reset)
      err_go |=> halt_ff)
      else $error("error did not halt stream");

   // A summary restarts the stream counters and the buffer.
   a_sum_restarts: assert property (@(posedge clock) disable iff (reset)
      sum_go |=> (in_count_ff == '0 && out_count_ff == '0 && cnt_ff == '0 && !fin_pend_ff))
      else $error("stream not restarted after summary");

   // A summary always closes the results of its request.
   a_sum_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> rsp_last_ff)
      else $error("summary not marked last");

endmodule
`default_nettype wire
